// ===== rtl/arcball_rotation_unit_defines.svh =====
// ----------------------------------------------------------------------------
// arcball rotation unit assertion macros
// shared assertion helpers, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef ARCBALL_ROTATION_UNIT_DEFINES_SVH
`define ARCBALL_ROTATION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define ARU_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ARU_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ARU_ASSERT(lbl, clk, rst_n, prop, msg)
`define ARU_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/aru_pkg.sv =====
// ----------------------------------------------------------------------------
// arcball rotation unit package
// shared widths, constants and status types
// ----------------------------------------------------------------------------
package aru_pkg;

    localparam int COORD_BITS = 13;
    localparam int SCALE_W    = 24;
    localparam int SQ_IN_W    = 64;
    localparam int SQ_OUT_W   = 32;
    localparam int SQ_CNT_W   = 6;
    localparam int DIV_N_W    = 48;
    localparam int DIV_D_W    = 32;
    localparam int DIV_Q_W    = 18;
    localparam int DIV_CNT_W  = 5;

    // configuration register indexes
    localparam logic [0:0] REG_SCALE_X = 1'b0;
    localparam logic [0:0] REG_SCALE_Y = 1'b1;

    // pointer operations
    localparam logic OP_CLICK = 1'b0;
    localparam logic OP_DRAG  = 1'b1;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_stat_t;

endpackage

// ===== rtl/aru_isqrt.sv =====
// ----------------------------------------------------------------------------
// arcball rotation unit square root
// digit-by-digit integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module aru_isqrt
    import aru_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [SQ_IN_W-1:0]  radicand,
    output logic [SQ_OUT_W-1:0] root,
    output unit_stat_t          stat
);

    logic [SQ_IN_W-1:0]  x_reg;
    logic [SQ_OUT_W+1:0] rem_reg;
    logic [SQ_OUT_W-1:0] root_reg;
    logic [SQ_CNT_W-1:0] cnt_reg;
    logic                busy_reg;
    logic                done_reg;

    logic [SQ_OUT_W+3:0] rem_sh;
    logic [SQ_OUT_W+3:0] trial;
    logic                ge;
    logic [SQ_OUT_W+3:0] rem_sub;

    assign rem_sh  = {rem_reg, x_reg[SQ_IN_W-1 -: 2]};
    assign trial   = {2'b00, root_reg, 2'b01};
    assign ge      = rem_sh >= trial;
    assign rem_sub = rem_sh - trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= SQ_CNT_W'(SQ_OUT_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == SQ_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[SQ_IN_W-3:0], 2'b00};
            rem_reg  <= ge ? rem_sub[SQ_OUT_W+1:0] : rem_sh[SQ_OUT_W+1:0];
            root_reg <= {root_reg[SQ_OUT_W-2:0], ge};
        end
    end

    assign root      = root_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/aru_div.sv =====
// ----------------------------------------------------------------------------
// arcball rotation unit divider
// restoring divider, one quotient bit per cycle, short quotient
// ----------------------------------------------------------------------------
module aru_div
    import aru_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [DIV_N_W-1:0] dividend,
    input  logic [DIV_D_W-1:0] divisor,
    output logic [DIV_Q_W-1:0] quotient,
    output unit_stat_t         stat
);

    localparam int DEN_W = DIV_D_W + DIV_Q_W;

    logic [DIV_N_W-1:0]   rem_reg;
    logic [DEN_W-1:0]     den_reg;
    logic [DIV_Q_W-1:0]   quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;

    logic ge;

    assign ge = DEN_W'(rem_reg) >= den_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= DIV_CNT_W'(DIV_Q_W);
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= dividend;
            den_reg <= {divisor, {(DIV_Q_W-1){1'b0}}, 1'b0} >> 1;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (ge)
            begin
                rem_reg <= rem_reg - den_reg[DIV_N_W-1:0];
            end
            den_reg <= den_reg >> 1;
            quo_reg <= {quo_reg[DIV_Q_W-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ===== rtl/arcball_rotation_unit.sv =====
// ----------------------------------------------------------------------------
// arcball rotation unit: two pointer positions to a rotation quaternion
// sphere mapping follows accept, using the root unit and, outside the sphere, two divides
// a drag then adds nine products and, unless the result is the identity, a root and four
// divides, plus any wait while the output word is still held
// one word at a time: s_tready is high only while idle; reset clears start
// vector, scales to their defaults and the output valid
// ----------------------------------------------------------------------------
`include "arcball_rotation_unit_defines.svh"

module arcball_rotation_unit
    import aru_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [31:0]         s_tdata,   // coord_x, coord_y
    input  logic [0:0]          s_tuser,   // operation
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [63:0]         m_tdata,   // quat_w, quat_x, quat_y, quat_z
    output logic [0:0]          m_tuser,   // is_identity
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [0:0]          cfg_index,
    input  logic [SCALE_W-1:0]  cfg_data
);

    localparam logic [4:0] ST_IDLE = 5'd0;
    localparam logic [4:0] ST_MX   = 5'd1;
    localparam logic [4:0] ST_MY   = 5'd2;
    localparam logic [4:0] ST_PY   = 5'd3;
    localparam logic [4:0] ST_NORM = 5'd4;
    localparam logic [4:0] ST_SQA  = 5'd5;
    localparam logic [4:0] ST_SQB  = 5'd6;
    localparam logic [4:0] ST_SQE  = 5'd7;
    localparam logic [4:0] ST_INS  = 5'd8;
    localparam logic [4:0] ST_XX   = 5'd9;
    localparam logic [4:0] ST_YY   = 5'd10;
    localparam logic [4:0] ST_DZ   = 5'd11;
    localparam logic [4:0] ST_ZW   = 5'd12;
    localparam logic [4:0] ST_LW   = 5'd13;
    localparam logic [4:0] ST_DX   = 5'd14;
    localparam logic [4:0] ST_DY   = 5'd15;
    localparam logic [4:0] ST_VEC  = 5'd16;
    localparam logic [4:0] ST_PRD  = 5'd17;
    localparam logic [4:0] ST_CC   = 5'd18;
    localparam logic [4:0] ST_TST  = 5'd19;
    localparam logic [4:0] ST_MN   = 5'd20;
    localparam logic [4:0] ST_NN   = 5'd21;
    localparam logic [4:0] ST_NS   = 5'd22;
    localparam logic [4:0] ST_NL   = 5'd23;
    localparam logic [4:0] ST_QD   = 5'd24;
    localparam logic [4:0] ST_QW   = 5'd25;
    localparam logic [4:0] ST_OUT  = 5'd26;

    localparam logic signed [63:0] ONE_Q22   = 64'sd4194304;
    localparam logic signed [63:0] ONE_Q32   = 64'sd4294967296;
    localparam logic signed [63:0] INSIDE_R2 = 64'sd17592186044416;
    localparam logic signed [63:0] IDENT_LIM = 64'sd33554432;
    localparam logic [63:0]        IDENT_WORD = 64'd16384;

    logic [4:0]               state_reg;
    logic [3:0]               idx_reg;
    logic                     op_reg;
    logic [COORD_BITS-1:0]    cx_reg;
    logic [COORD_BITS-1:0]    cy_reg;
    logic [SCALE_W-1:0]       sx_reg;
    logic [SCALE_W-1:0]       sy_reg;
    logic signed [63:0]       mul_reg;
    logic signed [63:0]       acc_reg;
    logic [37:0]              a_reg;
    logic [37:0]              b_reg;
    logic                     xn_reg;
    logic                     yn_reg;
    logic                     big_reg;
    logic [16:0]              xf_reg;
    logic [16:0]              yf_reg;
    logic [16:0]              z_reg;
    logic signed [17:0]       ex_reg;
    logic signed [17:0]       ey_reg;
    logic signed [17:0]       ez_reg;
    logic signed [17:0]       stx_reg;
    logic signed [17:0]       sty_reg;
    logic signed [17:0]       stz_reg;
    logic [31:0]              len_reg;
    logic signed [35:0]       q_reg [4];
    logic [35:0]              m_reg [4];
    logic signed [15:0]       res_reg [4];
    logic                     ident_reg;
    logic                     m_tvalid_reg;
    logic [63:0]              m_tdata_reg;
    logic                     m_tuser_reg;

    logic signed [32:0]       mul_a;
    logic signed [32:0]       mul_b;
    logic signed [65:0]       mul_full;

    logic signed [63:0]       px;
    logic signed [63:0]       py;
    logic signed [63:0]       px_neg;
    logic signed [63:0]       py_neg;
    logic signed [63:0]       d_val;
    logic [37:0]              a_rnd;
    logic [37:0]              b_rnd;
    logic signed [17:0]       vx;
    logic signed [17:0]       vy;
    logic signed [17:0]       vz;
    logic [1:0]               cq_idx;
    logic [35:0]              cq_mag;
    logic [36:0]              cq_rnd;
    logic [DIV_Q_W-1:0]       dv_quo;
    logic [16:0]              f_cap;
    logic [14:0]              r_cap;
    logic signed [15:0]       r_neg;
    logic                     out_free;
    logic                     quat_range_ok;

    logic                     sq_start;
    logic [SQ_IN_W-1:0]       sq_in;
    logic [SQ_OUT_W-1:0]      sq_root;
    unit_stat_t               sq_stat;
    logic                     dv_start;
    logic [DIV_N_W-1:0]       dv_num;
    logic [DIV_D_W-1:0]       dv_den;
    unit_stat_t               dv_stat;

    aru_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_in),
        .root     (sq_root),
        .stat     (sq_stat)
    );

    aru_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_num),
        .divisor  (dv_den),
        .quotient (dv_quo),
        .stat     (dv_stat)
    );

    // datapath helpers
    assign px     = mul_reg - ONE_Q22;
    assign py     = ONE_Q22 - mul_reg;
    assign px_neg = -px;
    assign py_neg = -py;
    assign d_val  = acc_reg - mul_reg;
    assign a_rnd  = a_reg + 38'd32;
    assign b_rnd  = b_reg + 38'd32;
    assign vx     = xn_reg ? -$signed({1'b0, xf_reg}) : $signed({1'b0, xf_reg});
    assign vy     = yn_reg ? -$signed({1'b0, yf_reg}) : $signed({1'b0, yf_reg});
    assign vz     = $signed({1'b0, z_reg});
    assign cq_idx = idx_reg[1:0] + 2'd1;
    assign cq_mag = q_reg[cq_idx][35] ? 36'(-q_reg[cq_idx]) : 36'(q_reg[cq_idx]);
    assign cq_rnd = {1'b0, cq_mag} + 37'd128;
    assign f_cap  = (dv_quo > 18'd65536) ? 17'h10000 : dv_quo[16:0];
    assign r_cap  = (dv_quo > 18'd16384) ? 15'd16384 : dv_quo[14:0];
    assign r_neg  = -$signed({1'b0, r_cap});
    assign out_free = !m_tvalid_reg || m_tready;

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_MX:
            begin
                mul_a = $signed(33'(cx_reg));
                mul_b = $signed(33'(sx_reg));
            end
            ST_MY:
            begin
                mul_a = $signed(33'(cy_reg));
                mul_b = $signed(33'(sy_reg));
            end
            ST_SQA:
            begin
                mul_a = $signed({1'b0, a_reg[31:0]});
                mul_b = $signed({1'b0, a_reg[31:0]});
            end
            ST_SQB:
            begin
                mul_a = $signed({1'b0, b_reg[31:0]});
                mul_b = $signed({1'b0, b_reg[31:0]});
            end
            ST_XX:
            begin
                mul_a = $signed(33'(xf_reg));
                mul_b = $signed(33'(xf_reg));
            end
            ST_YY:
            begin
                mul_a = $signed(33'(yf_reg));
                mul_b = $signed(33'(yf_reg));
            end
            ST_PRD:
            begin
                case (idx_reg)
                    4'd0:    begin mul_a = 33'(stx_reg); mul_b = 33'(ex_reg); end
                    4'd1:    begin mul_a = 33'(sty_reg); mul_b = 33'(ey_reg); end
                    4'd2:    begin mul_a = 33'(stz_reg); mul_b = 33'(ez_reg); end
                    4'd3:    begin mul_a = 33'(sty_reg); mul_b = 33'(ez_reg); end
                    4'd4:    begin mul_a = 33'(stz_reg); mul_b = 33'(ey_reg); end
                    4'd5:    begin mul_a = 33'(stz_reg); mul_b = 33'(ex_reg); end
                    4'd6:    begin mul_a = 33'(stx_reg); mul_b = 33'(ez_reg); end
                    4'd7:    begin mul_a = 33'(stx_reg); mul_b = 33'(ey_reg); end
                    4'd8:    begin mul_a = 33'(sty_reg); mul_b = 33'(ex_reg); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
            end
            ST_CC:
            begin
                mul_a = $signed(33'(cq_rnd[36:8]));
                mul_b = $signed(33'(cq_rnd[36:8]));
            end
            ST_NN:
            begin
                mul_a = $signed({3'b000, m_reg[idx_reg[1:0]][29:0]});
                mul_b = $signed({3'b000, m_reg[idx_reg[1:0]][29:0]});
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // unit launches
    always_comb
    begin
        sq_start = 1'b0;
        sq_in    = '0;
        dv_start = 1'b0;
        dv_num   = '0;
        dv_den   = '0;
        case (state_reg)
            ST_INS:
            begin
                sq_start = big_reg || (acc_reg > INSIDE_R2);
                sq_in    = acc_reg;
            end
            ST_DZ:
            begin
                sq_start = d_val > 64'sd0;
                sq_in    = d_val;
            end
            ST_NS:
            begin
                sq_start = 1'b1;
                sq_in    = acc_reg;
            end
            ST_LW:
            begin
                dv_start = sq_stat.done;
                dv_num   = {a_reg[31:0], 16'd0} + 48'(sq_root >> 1);
                dv_den   = sq_root;
            end
            ST_DX:
            begin
                dv_start = dv_stat.done;
                dv_num   = {b_reg[31:0], 16'd0} + 48'(len_reg >> 1);
                dv_den   = len_reg;
            end
            ST_QD:
            begin
                dv_start = 1'b1;
                dv_num   = {m_reg[idx_reg[1:0]][33:0], 14'd0} + 48'(len_reg >> 1);
                dv_den   = len_reg;
            end
            default:
            begin
                sq_start = 1'b0;
            end
        endcase
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            sx_reg       <= 24'd13128;
            sy_reg       <= 24'd17512;
            stx_reg      <= '0;
            sty_reg      <= '0;
            stz_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                case (cfg_index)
                    REG_SCALE_X: sx_reg <= cfg_data;
                    REG_SCALE_Y: sy_reg <= cfg_data;
                    default:     sx_reg <= sx_reg;
                endcase
            end
            if (state_reg == ST_OUT && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: if (s_tvalid) state_reg <= ST_MX;
                ST_MX:   state_reg <= ST_MY;
                ST_MY:   state_reg <= ST_PY;
                ST_PY:   state_reg <= ST_NORM;
                ST_NORM:
                begin
                    if (a_reg[37:30] == '0 && b_reg[37:30] == '0)
                    begin
                        state_reg <= ST_SQA;
                    end
                end
                ST_SQA:  state_reg <= ST_SQB;
                ST_SQB:  state_reg <= ST_SQE;
                ST_SQE:  state_reg <= ST_INS;
                ST_INS:  state_reg <= sq_start ? ST_LW : ST_XX;
                ST_XX:   state_reg <= ST_YY;
                ST_YY:   state_reg <= ST_DZ;
                ST_DZ:   state_reg <= sq_start ? ST_ZW : ST_VEC;
                ST_ZW:   if (sq_stat.done) state_reg <= ST_VEC;
                ST_LW:   if (sq_stat.done) state_reg <= ST_DX;
                ST_DX:   if (dv_stat.done) state_reg <= ST_DY;
                ST_DY:   if (dv_stat.done) state_reg <= ST_VEC;
                ST_VEC:
                begin
                    idx_reg <= '0;
                    if (op_reg == OP_DRAG)
                    begin
                        state_reg <= ST_PRD;
                    end
                    else
                    begin
                        stx_reg   <= vx;
                        sty_reg   <= vy;
                        stz_reg   <= vz;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_PRD:
                begin
                    if (idx_reg == 4'd9)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_CC;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_CC:
                begin
                    if (idx_reg == 4'd3)
                    begin
                        state_reg <= ST_TST;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_TST:  state_reg <= (acc_reg <= IDENT_LIM) ? ST_OUT : ST_MN;
                ST_MN:
                begin
                    if (m_reg[0][35:30] == '0 && m_reg[1][35:30] == '0 &&
                        m_reg[2][35:30] == '0 && m_reg[3][35:30] == '0)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_NN;
                    end
                end
                ST_NN:
                begin
                    if (idx_reg == 4'd4)
                    begin
                        state_reg <= ST_NS;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_NS:   state_reg <= ST_NL;
                ST_NL:
                begin
                    if (sq_stat.done)
                    begin
                        idx_reg   <= '0;
                        state_reg <= ST_QD;
                    end
                end
                ST_QD:   state_reg <= ST_QW;
                ST_QW:
                begin
                    if (dv_stat.done)
                    begin
                        if (idx_reg[1:0] == 2'd3)
                        begin
                            state_reg <= ST_OUT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= ST_QD;
                        end
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        mul_reg <= mul_full[63:0];
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_reg <= s_tuser[0];
                    cx_reg <= s_tdata[COORD_BITS-1:0];
                    cy_reg <= s_tdata[2*COORD_BITS-1:COORD_BITS];
                end
            end
            ST_MY:
            begin
                a_reg  <= px[63] ? px_neg[37:0] : px[37:0];
                xn_reg <= px[63];
            end
            ST_PY:
            begin
                b_reg   <= py[63] ? py_neg[37:0] : py[37:0];
                yn_reg  <= py[63];
                big_reg <= 1'b0;
            end
            ST_NORM:
            begin
                if (a_reg[37:30] != '0 || b_reg[37:30] != '0)
                begin
                    a_reg   <= a_reg >> 1;
                    b_reg   <= b_reg >> 1;
                    big_reg <= 1'b1;
                end
            end
            ST_SQB:  acc_reg <= mul_reg;
            ST_SQE:  acc_reg <= acc_reg + mul_reg;
            ST_INS:
            begin
                xf_reg <= a_rnd[22:6];
                yf_reg <= b_rnd[22:6];
            end
            ST_YY:   acc_reg <= ONE_Q32 - mul_reg;
            ST_DZ:   z_reg <= '0;
            ST_ZW:   if (sq_stat.done) z_reg <= sq_root[16:0];
            ST_LW:   if (sq_stat.done) len_reg <= sq_root;
            ST_DX:   if (dv_stat.done) xf_reg <= f_cap;
            ST_DY:
            begin
                if (dv_stat.done)
                begin
                    yf_reg <= f_cap;
                    z_reg  <= '0;
                end
            end
            ST_VEC:
            begin
                ex_reg   <= vx;
                ey_reg   <= vy;
                ez_reg   <= vz;
                q_reg[0] <= '0;
                q_reg[1] <= '0;
                q_reg[2] <= '0;
                q_reg[3] <= '0;
            end
            ST_PRD:
            begin
                case (idx_reg)
                    4'd1, 4'd2, 4'd3: q_reg[0] <= q_reg[0] + mul_reg[35:0];
                    4'd4:             q_reg[1] <= q_reg[1] + mul_reg[35:0];
                    4'd5:             q_reg[1] <= q_reg[1] - mul_reg[35:0];
                    4'd6:             q_reg[2] <= q_reg[2] + mul_reg[35:0];
                    4'd7:             q_reg[2] <= q_reg[2] - mul_reg[35:0];
                    4'd8:             q_reg[3] <= q_reg[3] + mul_reg[35:0];
                    4'd9:             q_reg[3] <= q_reg[3] - mul_reg[35:0];
                    default:          acc_reg  <= '0;
                endcase
                if (idx_reg == 4'd9)
                begin
                    acc_reg <= '0;
                end
            end
            ST_CC:   if (idx_reg != 4'd0) acc_reg <= acc_reg + mul_reg;
            ST_TST:
            begin
                ident_reg  <= acc_reg <= IDENT_LIM;
                res_reg[0] <= 16'sd16384;
                res_reg[1] <= '0;
                res_reg[2] <= '0;
                res_reg[3] <= '0;
                for (int i = 0; i < 4; i++)
                begin
                    m_reg[i] <= q_reg[i][35] ? 36'(-q_reg[i]) : 36'(q_reg[i]);
                end
                acc_reg <= '0;
            end
            ST_MN:
            begin
                if (m_reg[0][35:30] != '0 || m_reg[1][35:30] != '0 ||
                    m_reg[2][35:30] != '0 || m_reg[3][35:30] != '0)
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        m_reg[i] <= m_reg[i] >> 1;
                    end
                end
            end
            ST_NN:   if (idx_reg != 4'd0) acc_reg <= acc_reg + mul_reg;
            ST_NL:
            begin
                if (sq_stat.done)
                begin
                    len_reg <= (sq_root == '0) ? 32'd1 : sq_root;
                end
            end
            ST_QW:
            begin
                if (dv_stat.done)
                begin
                    res_reg[idx_reg[1:0]] <= q_reg[idx_reg[1:0]][35] ?
                                             r_neg : $signed({1'b0, r_cap});
                end
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    m_tdata_reg <= {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
                    m_tuser_reg <= ident_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign s_tready  = state_reg == ST_IDLE;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    // quaternion components stay within plus or minus one
    assign quat_range_ok =
        ($signed(m_tdata[15:0])  <= 16'sd16384) && ($signed(m_tdata[15:0])  >= -16'sd16384) &&
        ($signed(m_tdata[31:16]) <= 16'sd16384) && ($signed(m_tdata[31:16]) >= -16'sd16384) &&
        ($signed(m_tdata[47:32]) <= 16'sd16384) && ($signed(m_tdata[47:32]) >= -16'sd16384) &&
        ($signed(m_tdata[63:48]) <= 16'sd16384) && ($signed(m_tdata[63:48]) >= -16'sd16384);

    `ARU_ASSERT(a_idle_units, clk, rst_n, s_tready |-> !sq_stat.busy && !dv_stat.busy, "unit busy while idle")
    `ARU_ASSERT(a_ident_word, clk, rst_n, m_tvalid && m_tuser[0] |-> m_tdata == IDENT_WORD, "bad identity word")
    `ARU_ASSERT(a_quat_range, clk, rst_n, m_tvalid |-> quat_range_ok, "quaternion out of range")
    `ARU_ASSERT(a_one_unit, clk, rst_n, !(sq_stat.busy && dv_stat.busy), "root and divider both busy")

endmodule

// ===== dv/arcball_rotation_unit_tb.sv =====
// ----------------------------------------------------------------------------
// arcball rotation unit testbench
// drives click and drag pointer words, predicts each quaternion in fixed
// point and compares every whole output word against it, mostly under random idling
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module arcball_rotation_unit_tb
    import aru_pkg::*;
();

    localparam int FRAC   = 16;
    localparam int SFRAC  = 22;
    localparam int QONE   = 16384;
    localparam int WDOG   = 200000;

    typedef struct packed {
        logic [15:0] w;
        logic [15:0] x;
        logic [15:0] y;
        logic [15:0] z;
        logic        ident;
    } quat_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [0:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [0:0]  cfg_index;
    logic [SCALE_W-1:0] cfg_data;

    quat_t  quat_q[$];
    longint scale_x_m, scale_y_m;
    longint start_v[3];
    int     mismatches;
    int     idle_cnt;
    bit     tx_idle_en, rx_idle_en, rx_hold;

    arcball_rotation_unit dut (.*);

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    function automatic longint unsigned round_shift(longint unsigned m, int sh);
        return (m + (64'd1 << (sh - 1))) >> sh;
    endfunction

    function automatic longint absval(longint v);
        return v < 0 ? -v : v;
    endfunction

    task automatic map_to_sphere(input logic [12:0] cx, input logic [12:0] cy,
                                 output longint v[3]);
        longint px, py, d;
        longint unsigned a, b, xf, yf, r2, len, one;
        int s;
        one = 64'd1 << FRAC;
        px = longint'(cx) * scale_x_m - (64'sd1 << SFRAC);
        py = (64'sd1 << SFRAC) - longint'(cy) * scale_y_m;
        a = absval(px);
        b = absval(py);
        s = 0;
        while (a >= (64'd1 << 30) || b >= (64'd1 << 30))
        begin
            a >>= 1;
            b >>= 1;
            s++;
        end
        r2 = a * a + b * b;
        if (s == 0 && r2 <= (64'd1 << (2 * SFRAC)))
        begin
            xf = round_shift(a, SFRAC - FRAC);
            yf = round_shift(b, SFRAC - FRAC);
            d = longint'(one * one) - longint'(xf * xf) - longint'(yf * yf);
            v[2] = d > 0 ? longint'(int_sqrt(d)) : 0;
        end
        else
        begin
            len = int_sqrt(r2);
            xf = ((a << FRAC) + len / 2) / len;
            yf = ((b << FRAC) + len / 2) / len;
            if (xf > one) xf = one;
            if (yf > one) yf = one;
            v[2] = 0;
        end
        v[0] = px < 0 ? -longint'(xf) : longint'(xf);
        v[1] = py < 0 ? -longint'(yf) : longint'(yf);
    endtask

    task automatic predict_rotation(input bit op, input logic [12:0] cx,
                                    input logic [12:0] cy);
        longint e[3], q[4];
        longint unsigned m[4], c, sum, n2, len, r;
        quat_t res;
        logic [15:0] comp[4];
        map_to_sphere(cx, cy, e);
        if (op == OP_CLICK)
        begin
            start_v = e;
            return;
        end
        q[0] = start_v[0] * e[0] + start_v[1] * e[1] + start_v[2] * e[2];
        q[1] = start_v[1] * e[2] - start_v[2] * e[1];
        q[2] = start_v[2] * e[0] - start_v[0] * e[2];
        q[3] = start_v[0] * e[1] - start_v[1] * e[0];
        sum = 0;
        for (int i = 1; i < 4; i++)
        begin
            c = round_shift(absval(q[i]), 2 * FRAC - 24);
            sum += c * c;
        end
        if (sum <= (64'd1 << 25))
        begin
            res = '{w: 16'(QONE), x: 16'd0, y: 16'd0, z: 16'd0, ident: 1'b1};
            quat_q.push_back(res);
            return;
        end
        for (int i = 0; i < 4; i++) m[i] = absval(q[i]);
        while (m[0] >= (64'd1 << 30) || m[1] >= (64'd1 << 30) ||
               m[2] >= (64'd1 << 30) || m[3] >= (64'd1 << 30))
            for (int i = 0; i < 4; i++) m[i] >>= 1;
        n2 = 0;
        for (int i = 0; i < 4; i++) n2 += m[i] * m[i];
        len = int_sqrt(n2);
        if (len == 0) len = 1;
        for (int i = 0; i < 4; i++)
        begin
            r = (m[i] * QONE + len / 2) / len;
            if (r > QONE) r = QONE;
            comp[i] = q[i] < 0 ? 16'(-longint'(r)) : 16'(r);
        end
        res = '{w: comp[0], x: comp[1], y: comp[2], z: comp[3], ident: 1'b0};
        quat_q.push_back(res);
    endtask

    task automatic send_event(input bit op, input logic [12:0] cx, input logic [12:0] cy);
        while (tx_idle_en && $urandom_range(0, 99) < 16)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'd0, cy, cx};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        predict_rotation(op, cx, cy);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (quat_q.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
    endtask

    task automatic write_scale(input bit idx, input logic [SCALE_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_SCALE_X) scale_x_m = val;
        else scale_y_m = val;
        @(posedge clk);
    endtask

    // random drag session: a click then ndrag events, mostly drags
    task automatic random_session(input int ndrag);
        send_event(OP_CLICK, 13'($urandom), 13'($urandom));
        repeat (ndrag)
        begin
            if ($urandom_range(0, 3) == 0)
                send_event(1'($urandom), 13'($urandom), 13'($urandom));
            else
                send_event(OP_DRAG, 13'($urandom_range(0, 1400)),
                           13'($urandom_range(0, 1100)));
        end
    endtask

    task automatic test_directed();
        send_event(OP_DRAG, 13'd400, 13'd300);
        send_event(OP_CLICK, 13'd0, 13'd0);
        send_event(OP_DRAG, 13'd8191, 13'd8191);
        send_event(OP_DRAG, 13'd0, 13'd0);
        send_event(OP_CLICK, 13'd320, 13'd240);
        send_event(OP_DRAG, 13'd320, 13'd240);
        send_event(OP_DRAG, 13'd321, 13'd240);
        send_event(OP_DRAG, 13'd330, 13'd250);
        send_event(OP_DRAG, 13'd639, 13'd0);
        send_event(OP_DRAG, 13'd0, 13'd479);
        send_event(OP_CLICK, 13'd8191, 13'd0);
        send_event(OP_DRAG, 13'd0, 13'd8191);
        send_event(OP_DRAG, 13'd4096, 13'd2048);
        send_event(OP_DRAG, 13'h1555, 13'h0aaa);
        send_event(OP_CLICK, 13'h0aaa, 13'h1555);
        send_event(OP_DRAG, 13'd100, 13'd400);
        drain_results();
    endtask

    task automatic test_random(input int nitems);
        int sent;
        sent = 0;
        while (sent < nitems)
        begin
            random_session(7);
            sent += 8;
        end
        drain_results();
    endtask

    task automatic test_backpressure();
        rx_hold = 1'b1;
        fork
            random_session(6);
            begin
                repeat (1500) @(posedge clk);
                rx_hold = 1'b0;
            end
        join
        drain_results();
    endtask

    task automatic test_no_idle();
        tx_idle_en = 1'b0;
        rx_idle_en = 1'b0;
        test_random(120);
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
    endtask

    task automatic test_scales();
        write_scale(REG_SCALE_X, 24'hffffff);
        write_scale(REG_SCALE_Y, 24'h000000);
        test_random(40);
        write_scale(REG_SCALE_X, 24'h000000);
        write_scale(REG_SCALE_Y, 24'hffffff);
        test_random(40);
        write_scale(REG_SCALE_X, 24'd1024);
        write_scale(REG_SCALE_Y, 24'd1024);
        test_random(80);
        write_scale(REG_SCALE_X, 24'd13128);
        write_scale(REG_SCALE_Y, 24'd17512);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            m_tready <= !rx_hold && !(rx_idle_en && $urandom_range(0, 99) < 16);
    end

    always @(posedge clk)
    begin
        quat_t got, want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = '{w: m_tdata[15:0], x: m_tdata[31:16], y: m_tdata[47:32],
                    z: m_tdata[63:48], ident: m_tuser[0]};
            if (quat_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected word %h", got);
            end
            else
            begin
                want = quat_q.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp w=%0d x=%0d y=%0d z=%0d id=%0b got w=%0d x=%0d y=%0d z=%0d id=%0b",
                                 $signed(want.w), $signed(want.x), $signed(want.y),
                                 $signed(want.z), want.ident, $signed(got.w),
                                 $signed(got.x), $signed(got.y), $signed(got.z), got.ident);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            idle_cnt <= 0;
        else
            idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WDOG)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        idle_cnt = 0;
        mismatches = 0;
        tx_idle_en = 1'b1;
        rx_idle_en = 1'b1;
        rx_hold = 1'b0;
        scale_x_m = 13128;
        scale_y_m = 17512;
        start_v = '{0, 0, 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_backpressure();
        test_no_idle();
        test_scales();
        test_random(1100);
        if (mismatches == 0 && quat_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
